/* design/hsfc_pkg.sv */
// ----------------------------------------------------------------------------
// hsfc_pkg: shared types and constants for the half/single converter
// Command codes and the packed request and result payloads.
// ----------------------------------------------------------------------------
package hsfc_pkg;

	typedef enum logic {
		CMD_S2H = 1'b0,
		CMD_H2S = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [15:0] half_in;
		logic [31:0] single_in;
	} req_t;

	typedef struct packed {
		logic [31:0] single_out;
		logic [15:0] half_out;
	} res_t;

	localparam int unsigned REQ_W = 48;
	localparam int unsigned RES_W = 48;

endpackage

/* design/hsfc_convert.sv */
// ----------------------------------------------------------------------------
// hsfc_convert: combinational conversion of one request
// Single to half (truncating, clamped) or half to single (exact).
// ----------------------------------------------------------------------------
module hsfc_convert (
	input  hsfc_pkg::cmd_t cmd,
	input  hsfc_pkg::req_t req,
	output hsfc_pkg::res_t res
);
	import hsfc_pkg::*;

	logic [7:0] s_exp;
	logic [4:0] h_exp_o;
	logic [15:0] half_v;
	logic [4:0] h_exp;
	logic [9:0] h_frac;
	logic [3:0] lead;
	logic [3:0] norm_shift;
	logic [9:0] norm_frac;
	logic [7:0] se;
	logic [9:0] sf;
	logic [31:0] single_v;

	// single to half
	always_comb begin
		s_exp = req.single_in[30:23];
		if (s_exp == 8'd255) begin
			h_exp_o = 5'd31;
		end else if (s_exp <= 8'd113) begin
			h_exp_o = 5'd1;
		end else if (s_exp >= 8'd142) begin
			h_exp_o = 5'd30;
		end else begin
			h_exp_o = 5'(s_exp - 8'd112);
		end
		if (s_exp == 8'd0) begin
			half_v = {req.single_in[31], 15'd0};
		end else begin
			half_v = {req.single_in[31], h_exp_o, req.single_in[22:13]};
		end
	end

	// half to single; leading-one search over ten bits
	always_comb begin
		h_exp  = req.half_in[14:10];
		h_frac = req.half_in[9:0];
		lead   = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (h_frac[i]) lead = 4'(i);
		end
		norm_shift = 4'd10 - lead;
		norm_frac  = h_frac << norm_shift;
		if (h_exp == 5'd0) begin
			if (h_frac == 10'd0) begin
				se = 8'd0;
				sf = 10'd0;
			end else begin
				se = 8'd113 - {4'd0, norm_shift};
				sf = norm_frac;
			end
		end else if (h_exp == 5'd31) begin
			se = 8'd255;
			sf = h_frac;
		end else begin
			se = {3'd0, h_exp} + 8'd112;
			sf = h_frac;
		end
		single_v = {req.half_in[15], se, sf, 13'd0};
	end

	always_comb begin
		if (cmd == CMD_H2S) begin
			res.half_out   = 16'd0;
			res.single_out = single_v;
		end else begin
			res.half_out   = half_v;
			res.single_out = 32'd0;
		end
	end

endmodule

/* design/half_single_float_converter_unit.sv */
// ----------------------------------------------------------------------------
// half_single_float_converter_unit: IEEE half/single precision converter
// Converts one value per request in the direction given by tuser.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: tuser carries the command (0 = single to half,
//   1 = half to single); tdata holds single_in in [31:0], half_in in [47:32].
//   Master channel m_axis_*: tdata holds half_out in [15:0] and single_out in
//   [47:16]; the field for the unused direction is zero.
//   The result passes through the input register, then the conversion
//   logic, then the result register.
//   Throughput: one request per cycle while m_axis_tready is high; the two
//   register stages form an elastic pipeline, so a stage takes a new
//   request whenever it is empty or its content moves on in the same cycle.
//   Stall: when m_axis_tready is low the result register holds, the input
//   register fills behind it, then s_axis_tready drops.
//   Reset: arst_n clears both valid flags; the pipeline is empty.
// ----------------------------------------------------------------------------
module half_single_float_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // single_in[31:0], half_in[47:32]
	input  logic        s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // half_out[15:0], single_out[47:16]
);
	import hsfc_pkg::*;

	logic   vld_s1;
	req_t   req_s1;
	cmd_t   cmd_s1;
	logic   vld_s2;
	res_t   res_s2;
	res_t   res_c;
	logic   adv_s2;
	logic   adv_s1;

	// stage 2 takes data when empty or draining this cycle
	assign adv_s2 = !vld_s2 || m_axis_tready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			req_s1 <= req_t'(s_axis_tdata);
			cmd_s1 <= cmd_t'(s_axis_tuser);
		end
	end

	hsfc_convert u_convert (
		.cmd (cmd_s1),
		.req (req_s1),
		.res (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_c;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = res_s2;

`ifndef NO_ASSERTIONS
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && !m_axis_tready) |-> !s_axis_tready)
		else $error("request taken while pipeline full");
	a_hold_res: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res_s2.half_out == 16'd0 || res_s2.single_out == 32'd0))
		else $error("both result fields nonzero");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && adv_s2) |=> vld_s2)
		else $error("stage 1 request lost");
`endif

endmodule
